FILE: hw/rtl/brnf_pkg.sv
// ----------------------------------------------------------------------------
// brnf_pkg: shared types and constants of the box radius neighbor finder
// The package holds the stored agent record, the operation codes and the
// register indexes that the top level and the cells share.
// ----------------------------------------------------------------------------
package brnf_pkg;

  // Default depth of the agent table.
  localparam int MAX_AGENTS_DEF = 64;

  // Number of position axes of an agent.
  localparam int NUM_AXES = 4;

  // Field widths.
  localparam int ID_W   = 16;
  localparam int POS_W  = 32;
  localparam int RAD_W  = 31;
  localparam int DIMS_W = 3;
  // Window bounds hold position plus or minus radius without overflow.
  localparam int WIN_W  = POS_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RAD_W;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 3'd4;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;
  localparam logic [DIMS_W-1:0] DIMS_MAX   = 3'd4;

  // One stored agent.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] w;
  } agent_t;

endpackage

FILE: hw/rtl/brnf_cell.sv
// ----------------------------------------------------------------------------
// brnf_cell: one slot of the agent table
// Holds one agent. It takes a new agent on a load, or the agent of its
// upstream neighbor while the table rotates during a query.
// ----------------------------------------------------------------------------
module brnf_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  brnf_pkg::agent_t load_data,
  input  brnf_pkg::agent_t chain_in,
  output brnf_pkg::agent_t agent
);
  import brnf_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      agent <= load_data;
    end else if (shift) begin
      agent <= chain_in;
    end
  end

endmodule

FILE: hw/rtl/brnf_cmp.sv
// ----------------------------------------------------------------------------
// brnf_cmp: window check on one axis
// Tests whether a stored coordinate lies inside the seer's window
// [seer - radius, seer + radius]. A disabled axis always passes.
// ----------------------------------------------------------------------------
module brnf_cmp (
  input  logic                               en,
  input  logic signed [brnf_pkg::WIN_W-1:0]  lo,
  input  logic signed [brnf_pkg::WIN_W-1:0]  hi,
  input  logic signed [brnf_pkg::POS_W-1:0]  seen,
  output logic                               ok
);
  import brnf_pkg::*;

  logic signed [WIN_W-1:0] seen_ext;

  assign seen_ext = {{(WIN_W-POS_W){seen[POS_W-1]}}, seen};
  assign ok = !en || ((lo <= seen_ext) && (seen_ext <= hi));

endmodule

FILE: hw/rtl/box_radius_neighbor_finder.sv
// ----------------------------------------------------------------------------
// box_radius_neighbor_finder: brute-force fixed-radius neighbor search
// Keeps a table of seen agents in a ring of cells and, for a query, rotates
// the ring once past the shared window checkers, reporting matches in load order.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Handshake                 Payload
//  request    in         start, busy               op, agent_id, pos_x..pos_w
//  result     out        strobe (one cycle)        neighbor_id, found, last
//  config     in         cfg_we                    cfg_index, cfg_data
//
// A load or clear request is taken at once and busy never rises for it, so
// such requests may follow each other on every cycle. In a query the ring of
// cells rotates one place per cycle until every cell has passed the head,
// then the drain state empties the compare register and the done state puts
// out the final result; busy is high for that whole time. Results appear on
// the outputs in the cycle after the match is known to be a result, and the
// final result of a query shows up in the cycle when busy has just fallen.
// The receiver cannot stall the block; every strobe is a result taken.
// Reset (rst, synchronous, active high) empties the table, sets all radii to
// zero and dims to four. Table contents are not cleared; only the fill count
// decides which cells take part in a query.
// ----------------------------------------------------------------------------
module box_radius_neighbor_finder #(
  parameter int MAX_AGENTS = brnf_pkg::MAX_AGENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           op,
  input  logic [brnf_pkg::ID_W-1:0]            agent_id,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_x,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_y,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_z,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_w,
  // result channel
  output logic                                 strobe,
  output logic [brnf_pkg::ID_W-1:0]            neighbor_id,
  output logic                                 found,
  output logic                                 last,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [brnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brnf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import brnf_pkg::*;

  // Scan position counter width and fill count width (count reaches MAX).
  localparam int KW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CW = $clog2(MAX_AGENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RAD_W-1:0]  radius [NUM_AXES];
  logic [DIMS_W-1:0] dims;
  logic [DIMS_W-1:0] dims_sat;

  // Table control.
  logic [CW-1:0] count;
  logic [KW-1:0] scan_pos;

  // Query context.
  logic [ID_W-1:0]          seer_id;
  logic signed [WIN_W-1:0]  win_lo [NUM_AXES];
  logic signed [WIN_W-1:0]  win_hi [NUM_AXES];
  logic [NUM_AXES-1:0]      axis_en;

  // Compare stage and pending result.
  logic            hit_q;
  logic [ID_W-1:0] hit_id;
  logic            pend_v;
  logic [ID_W-1:0] pend_id;

  logic take;
  logic load_go;
  logic query_go;
  logic clear_go;
  logic shift;

  logic signed [POS_W-1:0] in_pos   [NUM_AXES];
  logic signed [POS_W-1:0] head_pos [NUM_AXES];
  logic [NUM_AXES-1:0]     axis_ok;
  logic                    head_hit;

  agent_t load_data;
  agent_t ring [MAX_AGENTS];

  assign busy     = (state != S_IDLE);
  assign take     = start && (state == S_IDLE);
  assign load_go  = take && (op == OP_LOAD) && (count < CW'(MAX_AGENTS));
  assign query_go = take && (op == OP_QUERY);
  assign clear_go = take && (op == OP_CLEAR);
  assign shift    = (state == S_SCAN);

  assign dims_sat = (dims > DIMS_MAX) ? DIMS_MAX : dims;

  assign in_pos[0] = pos_x;
  assign in_pos[1] = pos_y;
  assign in_pos[2] = pos_z;
  assign in_pos[3] = pos_w;

  assign load_data = '{id: agent_id, x: pos_x, y: pos_y, z: pos_z, w: pos_w};

  // The ring of cells: each cell passes its agent toward cell 0, and cell 0
  // wraps to the tail, so after MAX_AGENTS shifts the table is back in order.
  for (genvar i = 0; i < MAX_AGENTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_AGENTS;
    brnf_cell u_cell (
      .clk       (clk),
      .load      (load_go && (count == CW'(i))),
      .shift     (shift),
      .load_data (load_data),
      .chain_in  (ring[NXT]),
      .agent     (ring[i])
    );
  end

  // Cell 0 is the head of the ring; the window checkers look at it.
  assign head_pos[0] = ring[0].x;
  assign head_pos[1] = ring[0].y;
  assign head_pos[2] = ring[0].z;
  assign head_pos[3] = ring[0].w;

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
    brnf_cmp u_cmp (
      .en   (axis_en[j]),
      .lo   (win_lo[j]),
      .hi   (win_hi[j]),
      .seen (head_pos[j]),
      .ok   (axis_ok[j])
    );
  end

  // A head entry counts only while it is one of the filled slots and is not
  // the seer itself.
  assign head_hit = (CW'(scan_pos) < count) && (ring[0].id != seer_id) && (&axis_ok);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_pos <= '0;
      hit_q    <= 1'b0;
      pend_v   <= 1'b0;
      strobe   <= 1'b0;
      dims     <= DIMS_RESET;
      for (int j = 0; j < NUM_AXES; j++) begin
        radius[j] <= '0;
      end
    end else begin
      strobe <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS_X: radius[0] <= cfg_data;
          REG_RADIUS_Y: radius[1] <= cfg_data;
          REG_RADIUS_Z: radius[2] <= cfg_data;
          REG_RADIUS_W: radius[3] <= cfg_data;
          REG_DIMS:     dims      <= cfg_data[DIMS_W-1:0];
          default:      ;
        endcase
      end

      if (load_go) begin
        count <= count + CW'(1);
      end else if (clear_go) begin
        count <= '0;
      end

      hit_q <= shift && head_hit;

      // A new match pushes out the one held before it, which is then known
      // not to be the last.
      if (hit_q) begin
        pend_v <= 1'b1;
        if (pend_v) begin
          strobe <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (query_go) begin
            state    <= S_SCAN;
            scan_pos <= '0;
          end
        end
        S_SCAN: begin
          scan_pos <= scan_pos + KW'(1);
          if (scan_pos == KW'(MAX_AGENTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state  <= S_IDLE;
          strobe <= 1'b1;
          pend_v <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Query context and result payload.
  always_ff @(posedge clk) begin
    if (query_go) begin
      seer_id <= agent_id;
      for (int j = 0; j < NUM_AXES; j++) begin
        win_lo[j]  <= {{(WIN_W-POS_W){in_pos[j][POS_W-1]}}, in_pos[j]}
                      - {{(WIN_W-RAD_W){1'b0}}, radius[j]};
        win_hi[j]  <= {{(WIN_W-POS_W){in_pos[j][POS_W-1]}}, in_pos[j]}
                      + {{(WIN_W-RAD_W){1'b0}}, radius[j]};
        axis_en[j] <= (dims_sat > DIMS_W'(j));
      end
    end

    hit_id <= ring[0].id;

    if (hit_q) begin
      pend_id     <= hit_id;
      neighbor_id <= pend_id;
      found       <= 1'b1;
      last        <= 1'b0;
    end

    if (state == S_DONE) begin
      neighbor_id <= pend_v ? pend_id : '0;
      found       <= pend_v;
      last        <= 1'b1;
    end
  end

  // A result without a neighbor must close its query.
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !found |-> last)
    else $error("not-found result without last");

  // The final result of a query follows the done state.
  a_last_from_done: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> $past(state == S_DONE))
    else $error("last result outside query end");

  // The fill count never passes the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_AGENTS))
    else $error("table fill count overflow");

  // Compare hits exist only while a query walks the ring.
  a_hit_in_query: assert property (@(posedge clk) disable iff (rst)
    hit_q |-> (state == S_SCAN) || (state == S_DRAIN))
    else $error("compare hit outside a query");

  // Reset returns the sequencer to idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == S_IDLE) && !strobe)
    else $error("not idle after reset");

endmodule

FILE: dv/brnf_neighbor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brnf_neighbor_checker: result checker of the box radius neighbor finder
// Watches the request, result and register channels, keeps its own copy of
// the agent table and the radii, and compares every result with the one that
// the table predicts.
// ----------------------------------------------------------------------------
module brnf_neighbor_checker #(
  parameter int MAX_AGENTS = brnf_pkg::MAX_AGENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           op,
  input  logic [brnf_pkg::ID_W-1:0]            agent_id,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_x,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_y,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_z,
  input  logic signed [brnf_pkg::POS_W-1:0]    pos_w,
  input  logic                                 strobe,
  input  logic [brnf_pkg::ID_W-1:0]            neighbor_id,
  input  logic                                 found,
  input  logic                                 last,
  input  logic                                 cfg_we,
  input  logic [brnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brnf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   error_count,
  output int                                   results_due
);
  import brnf_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            found;
    logic            last;
  } neighbor_t;

  agent_t           agent_table [MAX_AGENTS];
  int               fill;
  logic [RAD_W-1:0] radius [NUM_AXES];
  logic [DIMS_W-1:0] dims;
  neighbor_t        due_q [$];
  int               mismatches = 0;

  // The difference is formed at 33 bits, so it never wraps.
  function automatic logic within_radius(input logic [POS_W-1:0] seer,
                                         input logic [POS_W-1:0] seen,
                                         input logic [RAD_W-1:0] r);
    logic signed [POS_W:0] gap;
    logic signed [POS_W:0] reach;
    gap   = {seer[POS_W-1], seer} - {seen[POS_W-1], seen};
    reach = {2'b00, r};
    return (gap <= reach) && (gap >= -reach);
  endfunction

  task automatic search_table(input logic [ID_W-1:0] seer_id,
                              input logic [POS_W-1:0] px, py, pz, pw);
    int        axes;
    logic      match;
    neighbor_t hit;
    neighbor_t hits_q [$];
    axes = (dims > DIMS_MAX) ? int'(DIMS_MAX) : int'(dims);
    for (int i = 0; i < fill; i++) begin
      if (agent_table[i].id != seer_id) begin
        match = 1'b1;
        if (axes > 0 && !within_radius(px, agent_table[i].x, radius[0])) match = 1'b0;
        if (axes > 1 && !within_radius(py, agent_table[i].y, radius[1])) match = 1'b0;
        if (axes > 2 && !within_radius(pz, agent_table[i].z, radius[2])) match = 1'b0;
        if (axes > 3 && !within_radius(pw, agent_table[i].w, radius[3])) match = 1'b0;
        if (match) begin
          hit.id    = agent_table[i].id;
          hit.found = 1'b1;
          hit.last  = 1'b0;
          hits_q.push_back(hit);
        end
      end
    end
    if (hits_q.size() == 0) begin
      hit.id    = '0;
      hit.found = 1'b0;
      hit.last  = 1'b1;
      due_q.push_back(hit);
    end else begin
      for (int k = 0; k < hits_q.size(); k++) begin
        hit      = hits_q[k];
        hit.last = (k == hits_q.size() - 1);
        due_q.push_back(hit);
      end
    end
  endtask

  always @(posedge clk) begin
    neighbor_t want;
    if (rst) begin
      fill = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        radius[a] = '0;
      end
      dims = DIMS_RESET;
      due_q.delete();
    end else begin
      // A result leaving in the same cycle as a new request belongs to the
      // older query, so it is checked before the new one is predicted.
      if (strobe) begin
        if (due_q.size() == 0) begin
          $error("result with none expected: neighbor_id %h found %b last %b",
                 neighbor_id, found, last);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (neighbor_id !== want.id) begin
            $error("neighbor_id: expected %h, actual %h", want.id, neighbor_id);
            mismatches++;
          end
          if (found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, found);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            mismatches++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS_X: radius[0] = cfg_data;
          REG_RADIUS_Y: radius[1] = cfg_data;
          REG_RADIUS_Z: radius[2] = cfg_data;
          REG_RADIUS_W: radius[3] = cfg_data;
          REG_DIMS:     dims = cfg_data[DIMS_W-1:0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        case (op_t'(op))
          OP_LOAD: begin
            if (fill < MAX_AGENTS) begin
              agent_table[fill].id = agent_id;
              agent_table[fill].x  = pos_x;
              agent_table[fill].y  = pos_y;
              agent_table[fill].z  = pos_z;
              agent_table[fill].w  = pos_w;
              fill++;
            end
          end
          OP_CLEAR: fill = 0;
          OP_QUERY: search_table(agent_id, pos_x, pos_y, pos_z, pos_w);
          default: ;
        endcase
      end
    end
    results_due <= due_q.size();
    error_count <= mismatches;
  end

endmodule

FILE: dv/tb_box_radius_neighbor_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_radius_neighbor_finder: testbench of the box radius neighbor finder
// Drives load, query and clear requests and register writes into the block,
// first a directed set of corner cases and then random phases of table fills
// and queries, while a checker beside the block predicts and checks results.
// ----------------------------------------------------------------------------
module tb_box_radius_neighbor_finder;
  import brnf_pkg::*;

  localparam int AGENTS       = MAX_AGENTS_DEF;
  localparam int RANDOM_ITEMS = 320;

  localparam logic [POS_W-1:0] POS_ZERO = 32'h0000_0000;
  localparam logic [POS_W-1:0] POS_ONE  = 32'h0000_0001;
  localparam logic [POS_W-1:0] POS_NEG1 = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN  = 32'h8000_0000;
  localparam logic [RAD_W-1:0] RAD_MAX  = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              op = OP_NONE;
  logic [ID_W-1:0]         agent_id = '0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic signed [POS_W-1:0] pos_w = '0;
  logic                    strobe;
  logic [ID_W-1:0]         neighbor_id;
  logic                    found;
  logic                    last;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int error_count;
  int results_due;

  // Requests sent with a real op code; the unused op code is not counted.
  int requests_sent = 0;
  // While set, the sender never leaves a gap between requests.
  bit steady = 1'b0;

  box_radius_neighbor_finder DUT (.*);

  brnf_neighbor_checker neighbor_check (.*);

  always #4 clk = ~clk;

  // The run is ended here if the block stops answering. A correct run takes
  // well under a tenth of this time, even with every query at full table.
  initial begin
    #4_000_000;
    $display("tb_box_radius_neighbor_finder failed");
    $finish;
  end

  // Presents one request and returns at the clock edge that accepts it. Start
  // is left high, so a following request goes out back to back unless the
  // sender decides to idle first. Now and then the gap is long enough that
  // the next request arrives in the middle of a query scan.
  task automatic issue(input op_t kind, input logic [ID_W-1:0] id,
                       input logic [POS_W-1:0] x, y, z, w);
    int gap;
    if (!steady && $urandom_range(99) < 27) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(70, 4) : $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= kind;
    agent_id <= id;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    pos_w    <= w;
    do @(posedge clk); while (busy);
    if (kind != OP_NONE) requests_sent++;
  endtask

  // Stops sending and waits until every predicted result has come out. Loads
  // and clears leave nothing to wait for, so a few more cycles let the last
  // of them settle in the table before anything else happens.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet. Only the low
  // bits of the dims word count, so the upper bits carry random junk, and
  // sometimes an index past the last register is written to show that it
  // changes nothing.
  task automatic program_box(input logic [RAD_W-1:0] rx, ry, rz, rw,
                             input logic [DIMS_W-1:0] d);
    logic [CFG_DATA_W-1:0] dims_word;
    settle_block();
    dims_word = CFG_DATA_W'($urandom());
    dims_word[DIMS_W-1:0] = d;
    if ($urandom_range(2) == 0) begin
      write_reg(REG_DIMS + CFG_IDX_W'($urandom_range(3, 1)), CFG_DATA_W'($urandom()));
    end
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Y, ry);
    write_reg(REG_RADIUS_Z, rz);
    write_reg(REG_RADIUS_W, rw);
    write_reg(REG_DIMS, dims_word);
    cfg_we <= 1'b0;
  endtask

  // Most agents come from a small pool of ids so that the seer often finds
  // its own id, or several copies of it, in the table.
  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(99) < 80) ? ID_W'($urandom_range(7)) : ID_W'($urandom());
  endfunction

  // Mostly a coordinate within spread of the hub; near the ends of the range the
  // sum wraps around, which gives the widest differences the block sees.
  function automatic logic [POS_W-1:0] near(input logic [POS_W-1:0] hub,
                                            input logic [POS_W-1:0] spread);
    if ($urandom_range(15) == 0) return POS_W'($urandom());
    return hub + POS_W'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic logic [POS_W-1:0] pick_hub();
    case ($urandom_range(5))
      0: return POS_MAX;
      1: return POS_MIN;
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius(input logic [POS_W-1:0] spread);
    case ($urandom_range(7))
      0: return '0;
      1: return RAD_MAX;
      2: return RAD_W'($urandom());
      3: return RAD_W'(spread >> 1);
      default: return RAD_W'(spread + (spread >> 1));
    endcase
  endfunction

  function automatic logic [DIMS_W-1:0] pick_dims();
    if ($urandom_range(3) == 0) return DIMS_W'($urandom_range(7));
    return DIMS_W'($urandom_range(4, 1));
  endfunction

  initial begin
    int               phase;
    int               goal;
    int               loads;
    int               queries;
    logic [POS_W-1:0] spread;
    logic [POS_W-1:0] hub [NUM_AXES];

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The radii start at zero and dims at four, so at first
    // only an exact match of all four coordinates counts.
    issue(OP_QUERY, 16'h0000, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
    issue(OP_LOAD, 16'h0001, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
    issue(OP_LOAD, 16'h0002, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    issue(OP_LOAD, 16'h0003, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
    issue(OP_LOAD, 16'h0001, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
    issue(OP_LOAD, 16'hFFFF, POS_ONE, POS_NEG1, POS_ZERO, POS_ZERO);
    // The seer shares its id with both exact matches, so nothing is found.
    issue(OP_QUERY, 16'h0001, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
    // Another id finds both copies of agent one.
    issue(OP_QUERY, 16'h0005, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
    // The unused op code must leave the table alone.
    issue(OP_NONE, 16'hFFFF, POS_NEG1, POS_NEG1, POS_NEG1, POS_NEG1);

    // Widest radii: the two opposite corners are still out of each other's reach.
    program_box(RAD_MAX, RAD_MAX, RAD_MAX, RAD_MAX, DIMS_MAX);
    issue(OP_QUERY, 16'h0002, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    issue(OP_QUERY, 16'h0003, POS_MIN, POS_MIN, POS_MIN, POS_MIN);

    // A dims value above four behaves as four.
    program_box(RAD_W'(1), RAD_W'(1), '0, '0, 3'd7);
    issue(OP_QUERY, 16'h0000, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);

    // With no axis compared, every agent with another id is a neighbor.
    program_box('0, '0, '0, '0, '0);
    issue(OP_QUERY, 16'h0001, POS_MIN, POS_MAX, POS_W'($urandom()), POS_W'($urandom()));

    // Only the first axis counts here, and then only the first two.
    program_box(RAD_W'(1), '0, '0, '0, 3'd1);
    issue(OP_QUERY, 16'h0000, POS_ONE, POS_MIN, POS_MAX, POS_ZERO);
    program_box('0, RAD_W'(1), '0, '0, 3'd2);
    issue(OP_QUERY, 16'h0007, POS_ZERO, POS_ZERO, POS_MAX, POS_MIN);

    // After a clear the table is empty again.
    issue(OP_CLEAR, 16'hFFFF, POS_NEG1, POS_NEG1, POS_NEG1, POS_NEG1);
    issue(OP_QUERY, 16'h0000, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);

    // Random part. Each phase picks a cluster and usually a set of radii scaled
    // to it, mostly clears the table, fills it, and then queries around the
    // cluster, with a little noise mixed in. Some fills run past capacity.
    // Reprogramming at the head of a phase first waits for every result.
    goal  = requests_sent + RANDOM_ITEMS;
    phase = 0;
    while (requests_sent < goal) begin
      steady = (phase >= 3 && phase < 6);
      spread = POS_W'(1) << $urandom_range(30);
      for (int a = 0; a < NUM_AXES; a++) begin
        hub[a] = pick_hub();
      end
      if (phase == 0 || $urandom_range(3) != 0) begin
        program_box(pick_radius(spread), pick_radius(spread), pick_radius(spread),
                    pick_radius(spread), pick_dims());
      end
      if ($urandom_range(9) < 6) begin
        issue(OP_CLEAR, ID_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
              POS_W'($urandom()), POS_W'($urandom()));
      end
      loads = ($urandom_range(5) == 0) ? $urandom_range(AGENTS + 6, AGENTS - 8)
                                       : $urandom_range(12, 1);
      repeat (loads) begin
        issue(OP_LOAD, pick_id(), near(hub[0], spread), near(hub[1], spread),
              near(hub[2], spread), near(hub[3], spread));
      end
      queries = $urandom_range(10, 2);
      repeat (queries) begin
        case ($urandom_range(19))
          0: issue(OP_NONE, ID_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
                   POS_W'($urandom()), POS_W'($urandom()));
          1: issue(OP_CLEAR, pick_id(), POS_W'($urandom()), POS_W'($urandom()),
                   POS_W'($urandom()), POS_W'($urandom()));
          2, 3: issue(OP_LOAD, pick_id(), near(hub[0], spread), near(hub[1], spread),
                      near(hub[2], spread), near(hub[3], spread));
          default: issue(OP_QUERY, pick_id(), near(hub[0], spread), near(hub[1], spread),
                         near(hub[2], spread), near(hub[3], spread));
        endcase
      end
      phase++;
    end
    steady = 1'b0;

    // Everything predicted must have come out, and a full query time more
    // passes so that a stray result would still be caught.
    settle_block();
    repeat (AGENTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_box_radius_neighbor_finder passed");
    end else begin
      $display("tb_box_radius_neighbor_finder failed");
    end
    $finish;
  end

endmodule
